// File: rtl/core/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

    // Internal byte-address width; wide enough for sums of two block sizes
    localparam int unsigned AW    = 20;
    localparam int unsigned TAG_W = 17;

    localparam logic [TAG_W-1:0] SIZE_MASK = 17'h1FFF8;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_INIT  = 2'd0;
    localparam cmd_t CMD_ALLOC = 2'd1;
    localparam cmd_t CMD_FREE  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STAT_DONE    = 2'd0;
    localparam status_t STAT_NOMEM   = 2'd1;
    localparam status_t STAT_IGNORED = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_INIT_W0,
        ST_INIT_W1,
        ST_INIT_W2,
        ST_INIT_W3,
        ST_FF_RD,
        ST_FF_CHK,
        ST_GROW,
        ST_GR_WH,
        ST_GR_WF,
        ST_GR_WE,
        ST_MG_R1,
        ST_MG_R2,
        ST_MG_R3,
        ST_MG_R4,
        ST_MG_R5,
        ST_MG_DEC,
        ST_MG_W1,
        ST_MG_W2,
        ST_MG_END,
        ST_PB_RD,
        ST_PB_DEC,
        ST_PB_W1,
        ST_PB_W2,
        ST_PB_W3,
        ST_PB_W4,
        ST_FR_RD,
        ST_FR_CHK,
        ST_FR_WH,
        ST_FR_WF,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/boundary_tag_first_fit_allocator.sv
// Time from acceptance to result valid depends on the command: an init is shorter when the chunk does not fit,
//   a free is shorter when the header check fails, and an allocate takes longer for each block visited
//   by the first-fit walk and again when the heap grows.
// Throughput: one item at a time; each tag access uses the single memory port, one per cycle.
// Reset (aresetn, synchronous, active low): control state idle, break 0 (not initialized),
//   chunk_bytes 4096; the tag memory is not cleared, the init command lays its tags down.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_first_fit_allocator #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_request_size,
    input  wire logic [15:0] s_block_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_payload_address,
    output logic [1:0]       m_status,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data
);

    localparam int unsigned AW         = bta_pkg::AW;
    localparam int unsigned TW         = bta_pkg::TAG_W;
    localparam int unsigned HEAP_LIMIT = (HEAP_BYTES > 65536) ? 65536 : HEAP_BYTES;
    localparam int unsigned DEPTH      = HEAP_LIMIT / 4;
    localparam int unsigned IW         = $clog2(DEPTH);
    localparam logic [AW-1:0] LIMIT    = AW'(HEAP_LIMIT);

    // Tag memory
    logic [TW-1:0] mem [DEPTH];
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [TW-1:0] mem_wdata;
    logic [TW-1:0] mem_q_reg;
    logic          oor_q_reg;
    logic          mem_inrange;
    logic [IW-1:0] mem_idx;

    assign mem_inrange = (mem_addr < LIMIT);
    assign mem_idx     = mem_addr[IW+1:2];

    always_ff @(posedge aclk) begin
        if (mem_we && mem_inrange) begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_idx];
            oor_q_reg <= !mem_inrange;
        end
    end

    // Registers
    bta_pkg::state_t  state_reg, state_next;
    bta_pkg::cmd_t    ctx_reg, ctx_next;
    logic [AW-1:0]    brk_reg, brk_next;
    logic [TW-1:0]    chunk_reg;
    logic [AW-1:0]    bp_reg, bp_next;
    logic [AW-1:0]    asize_reg, asize_next;
    logic [AW-1:0]    gsize_reg, gsize_next;
    logic [AW-1:0]    prev_reg, prev_next;
    logic [AW-1:0]    p3_reg, p3_next;
    logic             pa_reg, pa_next;
    logic [AW-1:0]    sz_reg, sz_next;
    logic [AW-1:0]    nb_reg, nb_next;
    logic [AW-1:0]    szn_reg, szn_next;
    logic [AW-1:0]    w1a_reg, w1a_next;
    logic [AW-1:0]    w2a_reg, w2a_next;
    logic [AW-1:0]    avail_reg, avail_next;
    logic             split_reg, split_next;
    logic [15:0]      res_addr_reg, res_addr_next;
    bta_pkg::status_t res_stat_reg, res_stat_next;
    logic             m_valid_reg;
    logic [15:0]      m_addr_reg;
    bta_pkg::status_t m_stat_reg;

    // Read data view
    logic [TW-1:0] rd_val;
    logic [AW-1:0] rd_size;
    logic          rd_alloc;

    assign rd_val   = oor_q_reg ? '0 : mem_q_reg;
    assign rd_size  = AW'(rd_val & bta_pkg::SIZE_MASK);
    assign rd_alloc = rd_val[0];

    // Shared conditions
    logic          accept;
    logic          out_free;
    logic [17:0]   ce_sum;
    logic [AW-1:0] ceff;
    logic [AW-1:0] req_asize;
    logic          alloc_ok;
    logic          free_pre_ok;
    logic          ff_end;
    logic          ff_hit;
    logic          grow_fail;
    logic          free_hdr_ok;
    logic          mg_skip;
    logic          pb_split;
    logic [AW-1:0] s_addr_ext;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign ce_sum      = {1'b0, chunk_reg} + 18'd7;
    assign ceff        = ((ce_sum & ~18'd7) == 18'd0) ? AW'(8) : AW'(ce_sum & ~18'd7);
    assign req_asize   = (AW'(s_request_size) + AW'(15)) & ~AW'(7);
    assign s_addr_ext  = AW'(s_block_address);
    assign alloc_ok    = (brk_reg != '0) && (s_request_size != 16'd0);
    assign free_pre_ok = (brk_reg != '0) && (s_block_address != 16'd0)
                         && (s_block_address[2:0] == 3'd0) && (s_addr_ext >= AW'(16))
                         && (s_addr_ext < brk_reg);
    assign ff_end      = (rd_size == '0);
    assign ff_hit      = (rd_size >= asize_reg) && !rd_alloc;
    assign grow_fail   = (brk_reg + gsize_reg) > LIMIT;
    assign free_hdr_ok = rd_alloc && (rd_size >= AW'(8)) && ((bp_reg + rd_size) <= brk_reg);
    assign mg_skip     = pa_reg && rd_alloc;
    assign pb_split    = (rd_size >= (asize_reg + AW'(8)));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bta_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (s_command == bta_pkg::CMD_INIT) begin
                        state_next = bta_pkg::ST_INIT_W0;
                    end else if (s_command == bta_pkg::CMD_ALLOC && alloc_ok) begin
                        state_next = bta_pkg::ST_FF_RD;
                    end else if (s_command == bta_pkg::CMD_FREE && free_pre_ok) begin
                        state_next = bta_pkg::ST_FR_RD;
                    end else begin
                        state_next = bta_pkg::ST_FIN;
                    end
                end
            end
            bta_pkg::ST_INIT_W0: state_next = bta_pkg::ST_INIT_W1;
            bta_pkg::ST_INIT_W1: state_next = bta_pkg::ST_INIT_W2;
            bta_pkg::ST_INIT_W2: state_next = bta_pkg::ST_INIT_W3;
            bta_pkg::ST_INIT_W3: state_next = bta_pkg::ST_GROW;
            bta_pkg::ST_FF_RD:   state_next = bta_pkg::ST_FF_CHK;
            bta_pkg::ST_FF_CHK: begin
                priority if (ff_end) begin
                    state_next = bta_pkg::ST_GROW;
                end else if (ff_hit) begin
                    state_next = bta_pkg::ST_PB_RD;
                end else begin
                    state_next = bta_pkg::ST_FF_CHK;
                end
            end
            bta_pkg::ST_GROW: begin
                state_next = grow_fail ? bta_pkg::ST_FIN : bta_pkg::ST_GR_WH;
            end
            bta_pkg::ST_GR_WH:  state_next = bta_pkg::ST_GR_WF;
            bta_pkg::ST_GR_WF:  state_next = bta_pkg::ST_GR_WE;
            bta_pkg::ST_GR_WE:  state_next = bta_pkg::ST_MG_R1;
            bta_pkg::ST_MG_R1:  state_next = bta_pkg::ST_MG_R2;
            bta_pkg::ST_MG_R2:  state_next = bta_pkg::ST_MG_R3;
            bta_pkg::ST_MG_R3:  state_next = bta_pkg::ST_MG_R4;
            bta_pkg::ST_MG_R4:  state_next = bta_pkg::ST_MG_R5;
            bta_pkg::ST_MG_R5:  state_next = bta_pkg::ST_MG_DEC;
            bta_pkg::ST_MG_DEC: begin
                state_next = mg_skip ? bta_pkg::ST_MG_END : bta_pkg::ST_MG_W1;
            end
            bta_pkg::ST_MG_W1:  state_next = bta_pkg::ST_MG_W2;
            bta_pkg::ST_MG_W2:  state_next = bta_pkg::ST_MG_END;
            bta_pkg::ST_MG_END: begin
                state_next = (ctx_reg == bta_pkg::CMD_ALLOC) ? bta_pkg::ST_PB_RD
                                                             : bta_pkg::ST_FIN;
            end
            bta_pkg::ST_PB_RD:  state_next = bta_pkg::ST_PB_DEC;
            bta_pkg::ST_PB_DEC: state_next = bta_pkg::ST_PB_W1;
            bta_pkg::ST_PB_W1:  state_next = bta_pkg::ST_PB_W2;
            bta_pkg::ST_PB_W2: begin
                state_next = split_reg ? bta_pkg::ST_PB_W3 : bta_pkg::ST_FIN;
            end
            bta_pkg::ST_PB_W3:  state_next = bta_pkg::ST_PB_W4;
            bta_pkg::ST_PB_W4:  state_next = bta_pkg::ST_FIN;
            bta_pkg::ST_FR_RD:  state_next = bta_pkg::ST_FR_CHK;
            bta_pkg::ST_FR_CHK: begin
                state_next = free_hdr_ok ? bta_pkg::ST_FR_WH : bta_pkg::ST_FIN;
            end
            bta_pkg::ST_FR_WH:  state_next = bta_pkg::ST_FR_WF;
            bta_pkg::ST_FR_WF:  state_next = bta_pkg::ST_MG_R1;
            bta_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = bta_pkg::ST_IDLE;
                end
            end
            default: state_next = bta_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and datapath
    always_comb begin
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = '0;
        mem_wdata     = '0;
        ctx_next      = ctx_reg;
        brk_next      = brk_reg;
        bp_next       = bp_reg;
        asize_next    = asize_reg;
        gsize_next    = gsize_reg;
        prev_next     = prev_reg;
        p3_next       = p3_reg;
        pa_next       = pa_reg;
        sz_next       = sz_reg;
        nb_next       = nb_reg;
        szn_next      = szn_reg;
        w1a_next      = w1a_reg;
        w2a_next      = w2a_reg;
        avail_next    = avail_reg;
        split_next    = split_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        unique case (state_reg)
            bta_pkg::ST_IDLE: begin
                // Latch the command and set up its first step
                if (accept) begin
                    ctx_next      = s_command;
                    res_addr_next = '0;
                    res_stat_next = bta_pkg::STAT_IGNORED;
                    asize_next    = req_asize;
                    bp_next       = s_addr_ext;
                    if (s_command == bta_pkg::CMD_INIT) begin
                        brk_next   = AW'(16);
                        gsize_next = ceff;
                    end else if (s_command == bta_pkg::CMD_ALLOC) begin
                        bp_next = AW'(8);
                    end
                end
            end
            bta_pkg::ST_INIT_W0: begin
                mem_we = 1'b1; mem_addr = AW'(0); mem_wdata = TW'(0);
            end
            bta_pkg::ST_INIT_W1: begin
                mem_we = 1'b1; mem_addr = AW'(4); mem_wdata = TW'(9);
            end
            bta_pkg::ST_INIT_W2: begin
                mem_we = 1'b1; mem_addr = AW'(8); mem_wdata = TW'(9);
            end
            bta_pkg::ST_INIT_W3: begin
                mem_we = 1'b1; mem_addr = AW'(12); mem_wdata = TW'(1);
            end
            bta_pkg::ST_FF_RD: begin
                mem_re = 1'b1; mem_addr = bp_reg - AW'(4);
            end
            bta_pkg::ST_FF_CHK: begin
                // Walk one block per cycle
                priority if (ff_end) begin
                    gsize_next = (asize_reg > ceff) ? asize_reg : ceff;
                end else if (!ff_hit) begin
                    bp_next  = bp_reg + rd_size;
                    mem_re   = 1'b1;
                    mem_addr = bp_reg + rd_size - AW'(4);
                end
            end
            bta_pkg::ST_GROW: begin
                if (grow_fail) begin
                    res_stat_next = bta_pkg::STAT_NOMEM;
                end else begin
                    bp_next  = brk_reg;
                    brk_next = brk_reg + gsize_reg;
                end
            end
            bta_pkg::ST_GR_WH: begin
                mem_we = 1'b1; mem_addr = bp_reg - AW'(4); mem_wdata = TW'(gsize_reg);
            end
            bta_pkg::ST_GR_WF: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + gsize_reg - AW'(8);
                mem_wdata = TW'(gsize_reg);
            end
            bta_pkg::ST_GR_WE: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + gsize_reg - AW'(4);
                mem_wdata = TW'(1);
            end
            // Fetch neighbor tags for coalescing
            bta_pkg::ST_MG_R1: begin
                mem_re = 1'b1; mem_addr = bp_reg - AW'(8);
            end
            bta_pkg::ST_MG_R2: begin
                prev_next = bp_reg - rd_size;
                mem_re    = 1'b1;
                mem_addr  = bp_reg - rd_size - AW'(4);
            end
            bta_pkg::ST_MG_R3: begin
                mem_re   = 1'b1;
                mem_addr = prev_reg + rd_size - AW'(8);
            end
            bta_pkg::ST_MG_R4: begin
                pa_next  = rd_alloc;
                p3_next  = rd_size;
                mem_re   = 1'b1;
                mem_addr = bp_reg - AW'(4);
            end
            bta_pkg::ST_MG_R5: begin
                sz_next  = rd_size;
                nb_next  = bp_reg + rd_size;
                mem_re   = 1'b1;
                mem_addr = bp_reg + rd_size - AW'(4);
            end
            bta_pkg::ST_MG_DEC: begin
                // Pick the merge case and, unless both neighbors are allocated, the two tag writes
                priority if (mg_skip) begin
                    bp_next = bp_reg;
                end else if (pa_reg) begin
                    szn_next = sz_reg + rd_size;
                    w1a_next = bp_reg - AW'(4);
                    w2a_next = bp_reg + AW'(TW'(sz_reg + rd_size) & bta_pkg::SIZE_MASK)
                               - AW'(8);
                end else if (rd_alloc) begin
                    szn_next = sz_reg + p3_reg;
                    w1a_next = prev_reg - AW'(4);
                    w2a_next = bp_reg + sz_reg - AW'(8);
                    bp_next  = prev_reg;
                end else begin
                    szn_next = sz_reg + rd_size + p3_reg;
                    w1a_next = prev_reg - AW'(4);
                    w2a_next = nb_reg + rd_size - AW'(8);
                    bp_next  = prev_reg;
                end
            end
            bta_pkg::ST_MG_W1: begin
                mem_we = 1'b1; mem_addr = w1a_reg; mem_wdata = TW'(szn_reg);
            end
            bta_pkg::ST_MG_W2: begin
                mem_we = 1'b1; mem_addr = w2a_reg; mem_wdata = TW'(szn_reg);
            end
            bta_pkg::ST_MG_END: begin
                res_stat_next = bta_pkg::STAT_DONE;
            end
            bta_pkg::ST_PB_RD: begin
                mem_re = 1'b1; mem_addr = bp_reg - AW'(4);
            end
            bta_pkg::ST_PB_DEC: begin
                avail_next = rd_size;
                split_next = pb_split;
            end
            // Mark the block allocated and, when it is large enough, split off the remainder
            bta_pkg::ST_PB_W1: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg - AW'(4);
                mem_wdata = TW'(split_reg ? asize_reg : avail_reg) | TW'(1);
                res_addr_next = bp_reg[15:0];
                res_stat_next = bta_pkg::STAT_DONE;
            end
            bta_pkg::ST_PB_W2: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + (split_reg ? asize_reg : avail_reg) - AW'(8);
                mem_wdata = TW'(split_reg ? asize_reg : avail_reg) | TW'(1);
            end
            bta_pkg::ST_PB_W3: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + asize_reg - AW'(4);
                mem_wdata = TW'(avail_reg - asize_reg);
            end
            bta_pkg::ST_PB_W4: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + avail_reg - AW'(8);
                mem_wdata = TW'(avail_reg - asize_reg);
            end
            bta_pkg::ST_FR_RD: begin
                mem_re = 1'b1; mem_addr = bp_reg - AW'(4);
            end
            bta_pkg::ST_FR_CHK: begin
                sz_next = rd_size;
            end
            bta_pkg::ST_FR_WH: begin
                mem_we = 1'b1; mem_addr = bp_reg - AW'(4); mem_wdata = TW'(sz_reg);
            end
            bta_pkg::ST_FR_WF: begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - AW'(8);
                mem_wdata = TW'(sz_reg);
            end
            bta_pkg::ST_FIN: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bta_pkg::ST_IDLE;
            brk_reg     <= '0;
            chunk_reg   <= TW'(4096);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
            if (cfg_wr_en) begin
                chunk_reg <= cfg_wr_data;
            end
            // Hold the result until taken
            if (state_reg == bta_pkg::ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ctx_reg      <= ctx_next;
        bp_reg       <= bp_next;
        asize_reg    <= asize_next;
        gsize_reg    <= gsize_next;
        prev_reg     <= prev_next;
        p3_reg       <= p3_next;
        pa_reg       <= pa_next;
        sz_reg       <= sz_next;
        nb_reg       <= nb_next;
        szn_reg      <= szn_next;
        w1a_reg      <= w1a_next;
        w2a_reg      <= w2a_next;
        avail_reg    <= avail_next;
        split_reg    <= split_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        if (state_reg == bta_pkg::ST_FIN && out_free) begin
            m_addr_reg <= res_addr_reg;
            m_stat_reg <= res_stat_reg;
        end
    end

    assign s_ready           = (state_reg == bta_pkg::ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_payload_address = m_addr_reg;
    assign m_status          = m_stat_reg;

`ifndef SYNTH
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !mem_re)
        else $error("tag memory read and write in the same cycle");

    a_brk_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        brk_reg <= LIMIT)
        else $error("heap break beyond heap limit");

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != bta_pkg::ST_IDLE)
        else $error("accepted item did not start work");

    a_addr_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != bta_pkg::STAT_DONE) |-> m_payload_address == 16'd0)
        else $error("failed item carries an address");
`endif

endmodule

`default_nettype wire

// File: tb/boundary_tag_allocator_checker.sv
`timescale 1ns / 1ps

module boundary_tag_allocator_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_request_size,
    input  wire logic [15:0] s_block_address,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_payload_address,
    input  wire logic [1:0]  m_status,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,
    output int               fail_count,
    output int               pending
);

    localparam int unsigned LIMIT_BYTES = 65536;
    localparam int unsigned DEPTH       = LIMIT_BYTES / 4;

    typedef struct packed {
        logic [15:0]      payload_address;
        bta_pkg::status_t status;
    } alloc_result_t;

    logic [16:0]   tag_words [DEPTH];
    int unsigned   brk;
    logic [16:0]   chunk;
    alloc_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic int unsigned tag_rd(int unsigned a);
        int unsigned i;
        i = a >> 2;
        return (i < DEPTH) ? int'(tag_words[i]) : 0;
    endfunction

    function automatic void tag_wr(int unsigned a, int unsigned v);
        int unsigned i;
        i = a >> 2;
        if (i < DEPTH) tag_words[i] = v[16:0];
    endfunction

    function automatic int unsigned tsz(int unsigned a);
        return tag_rd(a) & 32'h1FFF8;
    endfunction

    function automatic int unsigned talc(int unsigned a);
        return tag_rd(a) & 1;
    endfunction

    function automatic int unsigned next_bp(int unsigned bp);
        return bp + tsz(bp - 4);
    endfunction

    function automatic int unsigned prev_bp(int unsigned bp);
        return bp - tsz(bp - 8);
    endfunction

    function automatic int unsigned foot(int unsigned bp);
        return bp + tsz(bp - 4) - 8;
    endfunction

    // Join a free block with whichever neighbors are free
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned pa, na, sz;
        pa = talc(foot(prev_bp(bp)));
        na = talc(next_bp(bp) - 4);
        sz = tsz(bp - 4);
        if (pa && na) return bp;
        if (pa) begin
            sz += tsz(next_bp(bp) - 4);
            tag_wr(bp - 4, sz);
            tag_wr(foot(bp), sz);
        end else if (na) begin
            sz += tsz(foot(prev_bp(bp)));
            tag_wr(prev_bp(bp) - 4, sz);
            tag_wr(foot(bp), sz);
            bp = prev_bp(bp);
        end else begin
            sz += tsz(next_bp(bp) - 4) + tsz(foot(prev_bp(bp)));
            tag_wr(prev_bp(bp) - 4, sz);
            tag_wr(foot(next_bp(bp)), sz);
            bp = prev_bp(bp);
        end
        return bp;
    endfunction

    function automatic int unsigned heap_grow(int unsigned sz);
        int unsigned bp;
        if (sz > LIMIT_BYTES || brk > LIMIT_BYTES - sz) return 0;
        bp = brk;
        brk += sz;
        tag_wr(bp - 4, sz);
        tag_wr(foot(bp), sz);
        tag_wr(next_bp(bp) - 4, 1);
        return coalesce(bp);
    endfunction

    function automatic int unsigned growth_step();
        int unsigned c;
        c = (int'(chunk) + 7) & ~7;
        return (c != 0) ? c : 8;
    endfunction

    function automatic int unsigned scan_free(int unsigned asize);
        int unsigned bp, bs;
        bp = 8;
        bs = tsz(bp - 4);
        while (bs != 0) begin
            if (bs >= asize && talc(bp - 4) == 0) return bp;
            bp += bs;
            bs = tsz(bp - 4);
        end
        return 0;
    endfunction

    function automatic void place(int unsigned bp, int unsigned asize);
        int unsigned avail;
        avail = tsz(bp - 4);
        if (avail < asize + 8) begin
            tag_wr(bp - 4, avail | 1);
            tag_wr(foot(bp), avail | 1);
        end else begin
            tag_wr(bp - 4, asize | 1);
            tag_wr(foot(bp), asize | 1);
            tag_wr(next_bp(bp) - 4, avail - asize);
            tag_wr(foot(next_bp(bp)), avail - asize);
        end
    endfunction

    function automatic alloc_result_t predict_result(bta_pkg::cmd_t cmd, int unsigned req,
                                                     int unsigned p);
        alloc_result_t r;
        int unsigned asize, bp, c, h, sz;
        r.payload_address = '0;
        r.status = bta_pkg::STAT_IGNORED;
        if (cmd == bta_pkg::CMD_INIT) begin
            brk = 16;
            tag_wr(0, 0);
            tag_wr(4, 9);
            tag_wr(8, 9);
            tag_wr(12, 1);
            r.status = (heap_grow(growth_step()) != 0) ? bta_pkg::STAT_DONE
                                                       : bta_pkg::STAT_NOMEM;
        end else if (cmd == bta_pkg::CMD_ALLOC) begin
            if (brk != 0 && req != 0) begin
                asize = (req + 15) & ~7;
                bp = scan_free(asize);
                if (bp == 0) begin
                    c = growth_step();
                    bp = heap_grow(asize > c ? asize : c);
                end
                if (bp != 0) begin
                    place(bp, asize);
                    r.payload_address = bp[15:0];
                    r.status = bta_pkg::STAT_DONE;
                end else begin
                    r.status = bta_pkg::STAT_NOMEM;
                end
            end
        end else if (cmd == bta_pkg::CMD_FREE) begin
            if (brk != 0 && p != 0 && (p & 7) == 0 && p >= 16 && p < brk) begin
                h = tag_rd(p - 4);
                sz = h & 32'h1FFF8;
                if ((h & 1) && sz >= 8 && p + sz <= brk) begin
                    tag_wr(p - 4, sz);
                    tag_wr(foot(p), sz);
                    void'(coalesce(p));
                    r.status = bta_pkg::STAT_DONE;
                end
            end
        end
        return r;
    endfunction

    // Track configuration, predict each accepted item, check each result
    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (!aresetn) begin
            foreach (tag_words[i]) tag_words[i] = '0;
            brk = 0;
            chunk = 17'd4096;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) chunk = cfg_wr_data;
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_command, s_request_size,
                                                          s_block_address));
            if (m_valid && m_ready) begin
                got.payload_address = m_payload_address;
                got.status = m_status;
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation: addr %0d status %0d",
                           m_payload_address, m_status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.payload_address !== want.payload_address) begin
                        $error("payload_address expected %0d actual %0d",
                               want.payload_address, got.payload_address);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/boundary_tag_first_fit_allocator_test.sv
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_test;

    localparam int IDLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = bta_pkg::CMD_INIT;
    logic [15:0] s_request_size = '0;
    logic [15:0] s_block_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_payload_address;
    logic [1:0]  m_status;
    logic        cfg_wr_en = 1'b0;
    logic [16:0] cfg_wr_data = '0;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_cycle = 0;
    int          stall_mode = 0;
    logic [15:0] live_blocks [$];
    logic [15:0] last_freed = '0;

    boundary_tag_first_fit_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_request_size(s_request_size), .s_block_address(s_block_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload_address(m_payload_address),
        .m_status(m_status), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    boundary_tag_allocator_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_request_size(s_request_size), .s_block_address(s_block_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload_address(m_payload_address),
        .m_status(m_status), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Collect granted blocks so later frees hit real block starts
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_status == bta_pkg::STAT_DONE && m_payload_address != 0)
            live_blocks.push_back(m_payload_address);
    end

    // Stall the result channel: free-running, random, or mostly stalled
    always @(posedge aclk) begin
        stall_cycle++;
        if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("boundary_tag_first_fit_allocator test failed");
                $finish;
            end
        end
    end

    task automatic send_item(bta_pkg::cmd_t cmd, logic [15:0] req, logic [15:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_request_size <= req;
        s_block_address <= addr;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // Hold off until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_chunk(logic [16:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic free_live();
        int k;
        if (live_blocks.size() == 0) begin
            last_freed = '0;
            send_item(bta_pkg::CMD_FREE, 16'($urandom), 16'd0);
        end else begin
            k = $urandom_range(0, live_blocks.size() - 1);
            last_freed = live_blocks[k];
            live_blocks.delete(k);
            send_item(bta_pkg::CMD_FREE, 16'($urandom), last_freed);
        end
    endtask

    task automatic random_item();
        int pick;
        logic [15:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0: req = 16'($urandom_range(1, 65535));
                1, 2: req = 16'($urandom_range(257, 4096));
                default: req = 16'($urandom_range(1, 256));
            endcase
            send_item(bta_pkg::CMD_ALLOC, req, 16'($urandom));
        end else if (pick < 82) begin
            free_live();
        end else if (pick < 86) begin
            // free a live block, then free it again at once
            free_live();
            send_item(bta_pkg::CMD_FREE, 16'($urandom), last_freed);
        end else if (pick < 92) begin
            send_item(bta_pkg::CMD_FREE, 16'($urandom),
                      16'($urandom) | 16'($urandom_range(1, 7)));
        end else if (pick < 95) begin
            send_item(bta_pkg::CMD_FREE, 16'($urandom), 16'($urandom_range(0, 1) * 8));
        end else if (pick < 97) begin
            send_item(bta_pkg::CMD_ALLOC, 16'd0, 16'($urandom));
        end else begin
            send_item(bta_pkg::cmd_t'(2'd3), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic start_heap(logic [16:0] chunk_value);
        drain();
        write_chunk(chunk_value);
        live_blocks.delete();
        last_freed = '0;
        send_item(bta_pkg::CMD_INIT, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [16:0] chunk_values [8];
        logic [15:0] a;
        chunk_values = '{17'd8, 17'd0, 17'd7, 17'd65536, 17'd131071, 17'd256,
                         17'd1000, 17'd4096};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Before init every command but init is ignored
        send_item(bta_pkg::CMD_ALLOC, 16'd64, 16'd0);
        send_item(bta_pkg::CMD_FREE, 16'd0, 16'd24);
        send_item(bta_pkg::cmd_t'(2'd3), 16'hFFFF, 16'hFFFF);

        // Default chunk: edge sizes, bad frees, double free, growth
        send_item(bta_pkg::CMD_INIT, 16'd0, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'd0, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'd1, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'd4000, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'd8, 16'd0);
        send_item(bta_pkg::CMD_FREE, 16'd0, 16'd0);
        send_item(bta_pkg::CMD_FREE, 16'd0, 16'd8);
        send_item(bta_pkg::CMD_FREE, 16'd0, 16'd27);
        send_item(bta_pkg::CMD_FREE, 16'd0, 16'hFFFF);
        drain();
        free_live();
        a = last_freed;
        send_item(bta_pkg::CMD_FREE, 16'd0, a);
        free_live();
        free_live();
        send_item(bta_pkg::CMD_ALLOC, 16'd60000, 16'd0);
        send_item(bta_pkg::CMD_ALLOC, 16'd30000, 16'd0);
        send_item(bta_pkg::CMD_INIT, 16'd0, 16'd0);
        drain();
        live_blocks.delete();

        // Random traffic across several growth sizes
        foreach (chunk_values[i]) begin
            start_heap(chunk_values[i]);
            repeat (60) random_item();
        end
        start_heap(17'($urandom_range(1, 8192) * 8));
        repeat (20) random_item();

        drain();
        if (fail_count == 0) begin
            $display("boundary_tag_first_fit_allocator test passed");
        end else begin
            $display("boundary_tag_first_fit_allocator test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bta_pkg.sv
rtl/core/boundary_tag_first_fit_allocator.sv
tb/boundary_tag_allocator_checker.sv
tb/boundary_tag_first_fit_allocator_test.sv
